[rtl/core/pas_pkg.sv]
`default_nettype none

package pas_pkg;

	// register map
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_SENSITIVITY = 1'b0;

	// phase queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
	} q_stat_t;

	// pi * 2^60
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	// (2n)(2n+1) for the taylor terms
	localparam logic [63:0] TAYLOR_DIV [10] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420
	};

	// sine of r quarter-table steps, q2.30 series rounded to q1.15 and saturated
	function automatic logic [15:0] quadrant_entry(logic [63:0] r, int unsigned tb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		int unsigned n;
		x = ((PI_Q60 >> 24) * r) >> (tb + 5);
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
			if ((n & 1) != 0) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		v = (sum + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

	// full-turn table entry k for a table of 2^tb entries
	function automatic logic signed [15:0] sine_entry(int unsigned k, int unsigned tb);
		int unsigned quarter;
		int unsigned q;
		int unsigned r;
		logic signed [15:0] v;
		quarter = 1 << (tb - 2);
		q = (k >> (tb - 2)) & 3;
		r = k & (quarter - 1);
		if ((q & 1) != 0) begin
			v = $signed(quadrant_entry(64'(quarter - r), tb));
		end else begin
			v = $signed(quadrant_entry(64'(r), tb));
		end
		if ((q & 2) != 0) begin
			return -v;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/core/pas_front.sv]
`default_nettype none

module pas_front #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic signed [31:0]            sensitivity,
	input  wire pas_pkg::q_stat_t              q_stat,
	output logic                               push,
	output logic [31:0]                        push_phase
);

	localparam int unsigned PROD_W = 32 + SAMPLE_BITS;

	logic                     v_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic [31:0]              phase_q;
	logic [31:0]              inc;
	logic                     accept;

	// hold off while queue plus the word in flight could fill it
	assign in_stall = ({1'b0, q_stat.count} + {{pas_pkg::QCNT_W{1'b0}}, v_s1})
		>= (pas_pkg::QCNT_W + 1)'(pas_pkg::QDEPTH);
	assign accept = in_valid && !in_stall;

	// floor shift by SAMPLE_BITS-1, modulo 2^32
	assign inc = prod_s1[SAMPLE_BITS-1 +: 32];
	assign push = v_s1;
	assign push_phase = phase_q + inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			phase_q <= 32'd0;
		end else begin
			v_s1 <= accept;
			if (v_s1) begin
				phase_q <= push_phase;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= sensitivity * sample;
		end
	end

endmodule

`default_nettype wire

[rtl/core/pas_queue.sv]
`default_nettype none

module pas_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [31:0]      push_phase,
	input  wire logic             pop,
	output logic [31:0]           pop_phase,
	output pas_pkg::q_stat_t      q_stat
);

	logic [31:0]                 mem_q [pas_pkg::QDEPTH];
	logic [pas_pkg::QPTR_W-1:0]  wr_q;
	logic [pas_pkg::QPTR_W-1:0]  rd_q;
	logic [pas_pkg::QCNT_W-1:0]  count_q;

	assign pop_phase = mem_q[rd_q];
	assign q_stat.count = count_q;
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + {{(pas_pkg::QCNT_W-1){1'b0}}, push}
				- {{(pas_pkg::QCNT_W-1){1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_phase;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < pas_pkg::QCNT_W'(pas_pkg::QDEPTH)))
		else $error("phase queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("phase queue read while empty");

endmodule

`default_nettype wire

[rtl/core/pas_back.sv]
`default_nettype none

module pas_back #(
	parameter int unsigned TABLE_BITS = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pas_pkg::q_stat_t   q_stat,
	input  wire logic [31:0]        pop_phase,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      cos_value,
	output logic signed [15:0]      sin_value
);

	localparam int unsigned TBL_SIZE = 1 << TABLE_BITS;
	localparam int unsigned QUARTER = 1 << (TABLE_BITS - 2);
	localparam int unsigned FRAC_W = 32 - TABLE_BITS;
	localparam int unsigned PROD_W = FRAC_W + 18;
	localparam logic signed [PROD_W-1:0] ROUND =
		{{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

	typedef logic signed [15:0] rom_t [TBL_SIZE];

	function automatic rom_t build_rom(int unsigned shift);
		rom_t rom;
		int unsigned k;
		for (k = 0; k < TBL_SIZE; k++) begin
			rom[k] = pas_pkg::sine_entry((k + shift) & (TBL_SIZE - 1), TABLE_BITS);
		end
		return rom;
	endfunction

	// cosine table is the sine table rotated by a quarter turn
	localparam rom_t SIN_ROM = build_rom(0);
	localparam rom_t COS_ROM = build_rom(QUARTER);

	logic                     en1, en2, en3;
	logic                     v_s1, v_s2, v_s3;
	logic [TABLE_BITS-1:0]    idx0, idx1;
	logic signed [15:0]       t0s_s1, t1s_s1, t0c_s1, t1c_s1;
	logic [FRAC_W-1:0]        frac_s1;
	logic signed [16:0]       diffs, diffc;
	logic signed [15:0]       t0s_s2, t0c_s2;
	logic signed [PROD_W-1:0] prods_s2, prodc_s2;
	logic signed [PROD_W-1:0] rnds, rndc;
	logic signed [15:0]       sin_s3, cos_s3;

	assign en3 = !v_s3 || !out_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pop = !q_stat.empty && en1;

	assign idx0 = pop_phase[31 -: TABLE_BITS];
	assign idx1 = idx0 + 1'b1;

	assign diffs = {t1s_s1[15], t1s_s1} - {t0s_s1[15], t0s_s1};
	assign diffc = {t1c_s1[15], t1c_s1} - {t0c_s1[15], t0c_s1};

	assign rnds = prods_s2 + ROUND;
	assign rndc = prodc_s2 + ROUND;

	assign out_valid = v_s3;
	assign sin_value = sin_s3;
	assign cos_value = cos_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= pop;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// table read, registered
	always_ff @(posedge clk) begin
		if (en1) begin
			t0s_s1 <= SIN_ROM[idx0];
			t1s_s1 <= SIN_ROM[idx1];
			t0c_s1 <= COS_ROM[idx0];
			t1c_s1 <= COS_ROM[idx1];
			frac_s1 <= pop_phase[FRAC_W-1:0];
		end
	end

	// slope times fraction
	always_ff @(posedge clk) begin
		if (en2) begin
			t0s_s2 <= t0s_s1;
			t0c_s2 <= t0c_s1;
			prods_s2 <= diffs * $signed({1'b0, frac_s1});
			prodc_s2 <= diffc * $signed({1'b0, frac_s1});
		end
	end

	// round half up, floor shift, add base entry
	always_ff @(posedge clk) begin
		if (en3) begin
			sin_s3 <= t0s_s2 + rnds[FRAC_W +: 16];
			cos_s3 <= t0c_s2 + rndc[FRAC_W +: 16];
		end
	end

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped phase word lost before table read");

	a_word_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && en3) |=> v_s3)
		else $error("interpolated word lost before output");

endmodule

`default_nettype wire

[rtl/core/phase_accumulator_sincos.sv]
`default_nettype none

// Phase-accumulating cosine/sine generator. Each accepted sample adds
// (sensitivity * sample) >> (SAMPLE_BITS-1) to a 32-bit phase that spans one
// full turn and wraps by overflow; one word of cos_value and sin_value (q1.15)
// of the new phase comes out per sample, in order. Sustained rate is one sample
// per clock while neither in_stall nor out_stall holds it back. Each sample
// passes in order through the multiply, the phase add into a four-word queue,
// the table read, the slope multiply and the round and add before out_valid
// rises. Sine and cosine come from two constant tables of 2^TABLE_BITS entries
// with linear interpolation. sensitivity sits at byte address 0 of the apb
// port and should only be written while no samples are in flight.
module phase_accumulator_sincos #(
	parameter int unsigned TABLE_BITS = 10,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pas_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [15:0]                 cos_value,
	output logic signed [15:0]                 sin_value
);

	logic signed [31:0] sensitivity_q;
	logic               cfg_wr;
	logic               q_push;
	logic [31:0]        q_push_phase;
	logic               q_pop;
	logic [31:0]        q_pop_phase;
	pas_pkg::q_stat_t   q_stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == pas_pkg::REG_SENSITIVITY) ? sensitivity_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensitivity_q <= 32'sd0;
		end else if (cfg_wr && (paddr[2] == pas_pkg::REG_SENSITIVITY)) begin
			sensitivity_q <= pwdata;
		end
	end

	pas_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.sensitivity (sensitivity_q),
		.q_stat      (q_stat),
		.push        (q_push),
		.push_phase  (q_push_phase)
	);

	pas_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_phase (q_push_phase),
		.pop        (q_pop),
		.pop_phase  (q_pop_phase),
		.q_stat     (q_stat)
	);

	pas_back #(
		.TABLE_BITS (TABLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_phase (q_pop_phase),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cos_value (cos_value),
		.sin_value (sin_value)
	);

endmodule

`default_nettype wire
